/* rtl/pru_pkg.sv */
// Package with shared types and constants of the page replacement unit.
package pru_pkg;

	localparam int PAGES = 32;
	localparam int MAX_FRAMES = 32;
	localparam int PAGE_W = 5;
	localparam int FRAME_W = 5;
	localparam int OCC_W = 6;
	localparam int STEP_W = 7;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd1;

	localparam logic [2:0] POL_FIFO = 3'd0;
	localparam logic [2:0] POL_LRU = 3'd1;
	localparam logic [2:0] POL_OPT = 3'd2;
	localparam logic [2:0] POL_LFU = 3'd3;
	localparam logic [2:0] POL_CLOCK = 3'd4;

	localparam logic [31:0] STAMP_NEVER = 32'hFFFF_FFFF;
	localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFE;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

/* rtl/pru_order.sv */
// Load-order queue of resident pages with a one-entry-per-cycle shift port.
module pru_order #(
	parameter int DEPTH = 32,
	parameter int PW = 5
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [PW-1:0]            wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [PW-1:0]            rd_data
);
	logic [PW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

/* rtl/page_replacement_unit.sv */
// Top level of the page replacement unit.
// One page reference enters per transfer on the s_axis side and gives one result on the
// m_axis side. A reference that hits, or that faults into a free frame, passes through the
// accepting state, a lookup state and a final state that updates the page state and loads
// the output register. A fault that replaces a page walks the load-order queue one entry a
// cycle through a single compare unit: FIFO stops on the oldest page as the victim, LRU, OPT
// and LFU walk every resident page, and CLOCK may go round the queue a second time, because
// one full pass clears every reference bit. The gap the victim leaves in the queue is then
// closed by moving each newer entry down one position, and the new page goes to the newest
// position. The block takes one reference at a time; the next reference is accepted as soon
// as the block is idle, even while the previous result waits in the output register, and
// the block then holds in its final state until that register is free.
module page_replacement_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pru_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pru_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// virtual page [4:0], next_use_distance [24:5], zero fill [31:25]
	input  logic [31:0]                          s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// hit [0], frame [5:1], evicted [6], victim_page [11:7], fault_count [43:12], fill [47:44]
	output logic [47:0]                          m_axis_tdata
);
	import pru_pkg::*;

	// Configuration.
	logic [5:0] frame_count_q;
	logic [2:0] policy_q;

	// Per-page state.
	logic [PAGES-1:0]   resident_q;
	logic [FRAME_W-1:0] page_frame_q [PAGES];
	logic [31:0]        page_stamp_q [PAGES];
	logic [31:0]        use_count_q [PAGES];

	logic [OCC_W-1:0] occupancy_q;
	logic [31:0]      ref_index_q;
	logic [31:0]      fault_total_q;

	state_t state_q, state_d;

	// Current item.
	logic [PAGE_W-1:0]  page_q;
	logic [31:0]        stamp_q;
	logic [FRAME_W-1:0] pos_q;      // scan position
	logic [STEP_W-1:0]  step_q;     // scan step count
	logic [FRAME_W-1:0] best_pos_q;
	logic [31:0]        best_q;
	logic [FRAME_W-1:0] sh_q;       // shift position
	logic [PAGE_W-1:0]  victim_q;
	logic               hit_q;
	logic               evict_q;
	logic [FRAME_W-1:0] frame_q;

	// Output register.
	logic               out_valid_q;
	logic               o_hit_q, o_evicted_q;
	logic [FRAME_W-1:0] o_frame_q;
	logic [PAGE_W-1:0]  o_victim_q;
	logic [31:0]        o_faults_q;

	// Queue port.
	logic               q_we;
	logic [FRAME_W-1:0] q_waddr, q_raddr;
	logic [PAGE_W-1:0]  q_wdata, q_rdata;

	logic [OCC_W-1:0]   frames_used;
	logic               has_free;
	logic [FRAME_W-1:0] last_pos;
	logic [FRAME_W-1:0] pos_next;
	logic [STEP_W-1:0]  n_m1, n2_m1;
	logic [PAGE_W-1:0]  qp;
	logic [31:0]        cand;
	logic               better, take, clock_hit, clock_clear, scan_last;
	logic [FRAME_W-1:0] fin_pos;
	logic [PAGE_W-1:0]  fin_page;
	logic               accept_in;
	logic [PAGE_W-1:0]  in_page;
	logic [19:0]        dist_in;
	logic [31:0]        stamp_in;
	logic               out_free;
	logic               commit;

	pru_order #(.DEPTH(MAX_FRAMES), .PW(PAGE_W)) u_order (
		.clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
		.rd_addr(q_raddr), .rd_data(q_rdata)
	);

	// A frame count of zero acts as one, and counts above the frame store are clipped.
	always_comb begin
		if (frame_count_q == 6'd0) frames_used = OCC_W'(1);
		else if (frame_count_q > 6'(MAX_FRAMES)) frames_used = OCC_W'(MAX_FRAMES);
		else frames_used = frame_count_q;
	end

	assign has_free = occupancy_q < frames_used;
	assign last_pos = FRAME_W'(occupancy_q - OCC_W'(1));
	assign pos_next = (pos_q == last_pos) ? '0 : pos_q + FRAME_W'(1);
	assign n_m1 = STEP_W'(occupancy_q) - STEP_W'(1);
	assign n2_m1 = STEP_W'({occupancy_q, 1'b0}) - STEP_W'(1);

	// Page read out of the queue on this cycle (address issued on the cycle before).
	assign qp = q_rdata;

	// The one shared compare unit. Strict compares keep the oldest page on a tie.
	// FIFO and the unused policy codes stop on the oldest entry.
	always_comb begin
		cand = (policy_q == POL_LFU) ? use_count_q[qp] : page_stamp_q[qp];
		clock_hit = (policy_q == POL_CLOCK) && (page_stamp_q[qp] == 32'd0);
		case (policy_q)
			POL_LRU, POL_LFU: begin
				better = cand < best_q;
				scan_last = (step_q == n_m1);
			end
			POL_OPT: begin
				better = cand > best_q;
				scan_last = (step_q == n_m1);
			end
			POL_CLOCK: begin
				better = clock_hit;
				scan_last = clock_hit || (step_q == n2_m1);
			end
			default: begin
				better = 1'b0;
				scan_last = 1'b1;
			end
		endcase
		take = (step_q == '0) || better;
	end

	assign clock_clear = (policy_q == POL_CLOCK) && !clock_hit;
	assign fin_pos = take ? pos_q : best_pos_q;
	assign fin_page = take ? qp : victim_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign in_page = s_axis_tdata[PAGE_W-1:0];

	assign out_free = !out_valid_q || m_axis_tready;
	assign commit = (state_q == ST_DONE) && out_free;

	// Stamp of the incoming reference.
	assign dist_in = s_axis_tdata[24:5];
	always_comb begin
		case (policy_q)
			POL_OPT: begin
				if (dist_in == 20'd0) stamp_in = STAMP_NEVER;
				else if (ref_index_q >= STAMP_MAX - 32'(dist_in)) stamp_in = STAMP_MAX;
				else stamp_in = ref_index_q + 32'(dist_in);
			end
			POL_CLOCK: stamp_in = 32'd1;
			default:   stamp_in = ref_index_q;
		endcase
	end

	// Control. The scan reads one queue entry a cycle; the shift reads one entry ahead of
	// the entry it overwrites and finally puts the new page at the newest position.
	always_comb begin
		state_d = state_q;
		q_we = 1'b0;
		q_waddr = sh_q;
		q_wdata = q_rdata;
		q_raddr = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (resident_q[page_q]) state_d = ST_DONE;
				else if (has_free) begin
					q_we = 1'b1;
					q_waddr = FRAME_W'(occupancy_q);
					q_wdata = page_q;
					state_d = ST_DONE;
				end else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				q_raddr = pos_next;
				if (scan_last) begin
					q_raddr = fin_pos + FRAME_W'(1);
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				q_we = 1'b1;
				q_raddr = sh_q + FRAME_W'(2);
				if (sh_q == last_pos) begin
					q_wdata = page_q;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 6'd32;
			policy_q <= POL_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_COUNT: frame_count_q <= cfg_data;
				REG_POLICY:      policy_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Counters, residency and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q <= '0;
			occupancy_q <= '0;
			ref_index_q <= '0;
			fault_total_q <= '0;
			out_valid_q <= 1'b0;
			o_hit_q <= 1'b0;
			o_frame_q <= '0;
			o_evicted_q <= 1'b0;
			o_victim_q <= '0;
			o_faults_q <= '0;
			for (int i = 0; i < PAGES; i++) use_count_q[i] <= '0;
		end else begin
			if (accept_in && use_count_q[in_page] != COUNT_MAX)
				use_count_q[in_page] <= use_count_q[in_page] + 32'd1;
			if (state_q == ST_LOOK && !resident_q[page_q]) begin
				if (fault_total_q != COUNT_MAX) fault_total_q <= fault_total_q + 32'd1;
				if (has_free) occupancy_q <= occupancy_q + OCC_W'(1);
			end
			if (commit) begin
				ref_index_q <= ref_index_q + 32'd1;
				for (int i = 0; i < PAGES; i++) begin
					if (!hit_q && PAGE_W'(i) == page_q) resident_q[i] <= 1'b1;
					else if (evict_q && PAGE_W'(i) == victim_q) resident_q[i] <= 1'b0;
				end
				o_hit_q <= hit_q;
				o_frame_q <= frame_q;
				o_evicted_q <= evict_q;
				o_victim_q <= evict_q ? victim_q : '0;
				o_faults_q <= fault_total_q;
			end
			if (commit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current reference, frames and stamps.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					page_q <= in_page;
					stamp_q <= stamp_in;
					pos_q <= '0;
					step_q <= '0;
					evict_q <= 1'b0;
				end
			end
			ST_LOOK: begin
				hit_q <= resident_q[page_q];
				frame_q <= resident_q[page_q] ? page_frame_q[page_q] : FRAME_W'(occupancy_q);
				evict_q <= !resident_q[page_q] && !has_free;
			end
			ST_SCAN: begin
				step_q <= step_q + STEP_W'(1);
				pos_q <= pos_next;
				if (take) begin
					best_q <= cand;
					best_pos_q <= pos_q;
					victim_q <= qp;
				end
				if (clock_clear) page_stamp_q[qp] <= '0;
				if (scan_last) begin
					sh_q <= fin_pos;
					frame_q <= page_frame_q[fin_page];
				end
			end
			ST_SHIFT: sh_q <= sh_q + FRAME_W'(1);
			ST_DONE: begin
				if (out_free) begin
					page_stamp_q[page_q] <= stamp_q;
					if (!hit_q) page_frame_q[page_q] <= frame_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, o_faults_q, o_victim_q, o_evicted_q, o_frame_q, o_hit_q};

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("accepted while busy");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy_q <= OCC_W'(MAX_FRAMES)) else $error("occupancy overflow");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> m_axis_tvalid) else $error("result lost");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while waiting");
`endif
endmodule
